// File: hw/rtl/pdoq_pkg.sv
// Shared types, codes and the ordering rule of the priority and date ordered queue.
package pdoq_pkg;

	// Date and time of a request; the field order makes a plain compare lexicographic.
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} stamp_t;

	// One stored request, 56 bits.
	typedef struct packed {
		logic [7:0]  prio;
		stamp_t      stamp;
		logic [15:0] tag;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLACE,
		ST_POP_OUT
	} state_t;

	localparam logic       FUNC_PUSH  = 1'b0;
	localparam logic       FUNC_POP   = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// True when a stored entry belongs behind a newly pushed one.
	function automatic logic entry_follows(entry_t old_e, entry_t new_e);
		return (old_e.prio < new_e.prio) ||
			((old_e.prio == new_e.prio) && (old_e.stamp >= new_e.stamp));
	endfunction

endpackage

// File: hw/rtl/pdoq_ring_mem.sv
// Entry storage of the queue: one write port and one registered read port.
module pdoq_ring_mem #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  pdoq_pkg::entry_t           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output pdoq_pkg::entry_t           rdata
);
	import pdoq_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/priority_date_ordered_queue_top.sv
// Top level of the priority and date ordered request queue.
//
//  Channel   Direction  Handshake                  Payload
//  --------  ---------  -------------------------  ----------------------------------------
//  request   in         start high, busy low       func, req_priority .. req_minute, req_tag
//  result    out        done high for one cycle    out_valid, status, entry_count, out_*
//
// A push moves k stored entries one slot toward the tail before the request lands,
// where k is the number of entries that belong behind it (0 to the occupancy); the
// walk over the entry memory reads one entry per cycle and ends by raising done.
// A pop reads the head slot at the accepting edge and returns it next.
// A pop on an empty queue or a push on a full queue answers at once from the idle state.
// Reset clears the occupancy and the head pointer; the entry memory is not cleared.
// The receiver cannot stall: done is high for exactly one cycle per transaction.
module priority_date_ordered_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [7:0]  req_priority,
	input  logic [11:0] req_year,
	input  logic [3:0]  req_month,
	input  logic [4:0]  req_day,
	input  logic [4:0]  req_hour,
	input  logic [5:0]  req_minute,
	input  logic [15:0] req_tag,
	output logic        done,
	output logic        out_valid,
	output logic [1:0]  status,
	output logic [4:0]  entry_count,
	output logic [7:0]  out_priority,
	output logic [11:0] out_year,
	output logic [3:0]  out_month,
	output logic [4:0]  out_day,
	output logic [4:0]  out_hour,
	output logic [5:0]  out_minute,
	output logic [15:0] out_tag
);
	import pdoq_pkg::*;

	// Address width of the memory and width of a logical index or count.
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// The queue is kept as a ring: logical index 0 is the head slot.
	function automatic logic [AW-1:0] phys(logic [AW-1:0] head, logic [CW-1:0] idx);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(idx);
		if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	state_t         state_q, state_d;
	logic [CW-1:0]  occ_q, occ_d;
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  idx_q;
	logic           done_q;
	entry_t         req_q;

	logic           valid_q;
	logic [1:0]     status_q;
	logic [4:0]     count_q;
	entry_t         result_q;

	// Sequencer controls.
	logic           mem_re;
	logic           mem_we;
	logic [CW-1:0]  rd_idx;
	logic           wr_shift;
	logic           load_req;
	logic           idx_dec;
	logic           fin_push;
	logic           fin_pop;
	logic           imm_err;
	logic [1:0]     imm_status;

	entry_t         mem_rdata;
	entry_t         mem_wdata;
	entry_t         new_entry;

	assign new_entry = '{
		prio:  req_priority,
		stamp: '{year: req_year, month: req_month, day: req_day,
			hour: req_hour, minute: req_minute},
		tag:   req_tag
	};

	assign busy = (state_q != ST_IDLE);

	// A push walks backward from the tail. Each cycle it compares the entry just read
	// with the new request: an entry that belongs behind the request moves one slot
	// toward the tail and the next one is read; otherwise, or once the head entry has
	// moved, the request lands in the slot left free.
	always_comb begin
		state_d    = state_q;
		mem_re     = 1'b0;
		mem_we     = 1'b0;
		rd_idx     = '0;
		wr_shift   = 1'b0;
		load_req   = 1'b0;
		idx_dec    = 1'b0;
		fin_push   = 1'b0;
		fin_pop    = 1'b0;
		imm_err    = 1'b0;
		imm_status = STAT_OK;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (func == FUNC_PUSH) begin
						if (occ_q == CW'(QUEUE_DEPTH)) begin
							imm_err    = 1'b1;
							imm_status = STAT_FULL;
						end else begin
							load_req = 1'b1;
							if (occ_q == '0) begin
								state_d = ST_PLACE;
							end else begin
								mem_re  = 1'b1;
								rd_idx  = occ_q - CW'(1);
								state_d = ST_SCAN;
							end
						end
					end else begin
						if (occ_q == '0) begin
							imm_err    = 1'b1;
							imm_status = STAT_EMPTY;
						end else begin
							mem_re  = 1'b1;
							rd_idx  = '0;
							state_d = ST_POP_OUT;
						end
					end
				end
			end
			ST_SCAN: begin
				mem_we = 1'b1;
				if (entry_follows(mem_rdata, req_q)) begin
					wr_shift = 1'b1;
					idx_dec  = 1'b1;
					if (idx_q == CW'(1)) begin
						state_d = ST_PLACE;
					end else begin
						mem_re = 1'b1;
						rd_idx = idx_q - CW'(2);
					end
				end else begin
					fin_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_PLACE: begin
				mem_we   = 1'b1;
				fin_push = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_POP_OUT: begin
				fin_pop = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign mem_wdata = wr_shift ? mem_rdata : req_q;

	always_comb begin
		occ_d = occ_q;
		if (fin_push) begin
			occ_d = occ_q + CW'(1);
		end else if (fin_pop) begin
			occ_d = occ_q - CW'(1);
		end
	end

	pdoq_ring_mem #(
		.DEPTH (QUEUE_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (phys(head_q, idx_q)),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (phys(head_q, rd_idx)),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q   <= '0;
			head_q  <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			done_q  <= imm_err | fin_push | fin_pop;
			if (fin_pop) begin
				head_q <= phys(head_q, CW'(1));
			end
			if (load_req) begin
				idx_q <= occ_q;
			end else if (idx_dec) begin
				idx_q <= idx_q - CW'(1);
			end
		end
	end

	// The request and the result registers carry payload only.
	always_ff @(posedge clk) begin
		if (load_req) begin
			req_q <= new_entry;
		end
		if (imm_err | fin_push | fin_pop) begin
			valid_q  <= fin_pop;
			status_q <= imm_err ? imm_status : STAT_OK;
			count_q  <= 5'(occ_d);
			result_q <= fin_pop ? mem_rdata : '0;
		end
	end

	assign done         = done_q;
	assign out_valid    = valid_q;
	assign status       = status_q;
	assign entry_count  = count_q;
	assign out_priority = result_q.prio;
	assign out_year     = result_q.stamp.year;
	assign out_month    = result_q.stamp.month;
	assign out_day      = result_q.stamp.day;
	assign out_hour     = result_q.stamp.hour;
	assign out_minute   = result_q.stamp.minute;
	assign out_tag      = result_q.tag;

	// The occupancy never goes beyond the depth of the memory.
	assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(QUEUE_DEPTH))
		else $error("occupancy exceeds the queue depth");

	// The entry memory is written only while a push transaction is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SCAN || state_q == ST_PLACE))
		else $error("memory write outside a push");

	// A push on a full queue answers at once with the full status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_PUSH && occ_q == CW'(QUEUE_DEPTH))
		|=> (done && status == STAT_FULL && !out_valid))
		else $error("push on full not reported");

	// A returned entry always comes with the ok status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_valid) |-> (status == STAT_OK))
		else $error("returned entry with an error status");

endmodule

// File: tb/sv/pdoq_result_checker.sv
// Checker for the priority and date ordered queue: tracks the queue contents and compares results.
`timescale 1ns / 100ps

module pdoq_result_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        func,
	input  logic [7:0]  req_priority,
	input  logic [11:0] req_year,
	input  logic [3:0]  req_month,
	input  logic [4:0]  req_day,
	input  logic [4:0]  req_hour,
	input  logic [5:0]  req_minute,
	input  logic [15:0] req_tag,
	input  logic        done,
	input  logic        out_valid,
	input  logic [1:0]  status,
	input  logic [4:0]  entry_count,
	input  logic [7:0]  out_priority,
	input  logic [11:0] out_year,
	input  logic [3:0]  out_month,
	input  logic [4:0]  out_day,
	input  logic [4:0]  out_hour,
	input  logic [5:0]  out_minute,
	input  logic [15:0] out_tag,
	output int unsigned mismatch_count,
	output int unsigned results_awaited
);
	import pdoq_pkg::*;

	typedef struct packed {
		logic       valid;
		logic [1:0] code;
		logic [4:0] count;
		entry_t     ent;
	} outcome_t;

	entry_t   held_entries[$];
	outcome_t awaited_results[$];

	initial begin
		mismatch_count  = 0;
		results_awaited = 0;
	end

	task automatic report_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
		mismatch_count++;
	endtask

	task automatic compare_field(input string field, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report_mismatch(field, got, want);
		end
	endtask

	// Applies one request to the tracked queue and returns the result it must produce.
	function automatic outcome_t apply_request(input logic op, input entry_t req);
		outcome_t res;
		int       pos;
		res = '0;
		res.code = STAT_OK;
		if (op == FUNC_PUSH) begin
			if (held_entries.size() >= QUEUE_DEPTH) begin
				res.code = STAT_FULL;
			end else begin
				// Go past entries of higher or equal priority, then back over the
				// equal-priority ones whose date is not earlier than the new one.
				pos = 0;
				while (pos < held_entries.size() && held_entries[pos].prio >= req.prio)
					pos++;
				while (pos > 0 && held_entries[pos - 1].prio == req.prio &&
						held_entries[pos - 1].stamp >= req.stamp)
					pos--;
				held_entries.insert(pos, req);
			end
		end else if (held_entries.size() == 0) begin
			res.code = STAT_EMPTY;
		end else begin
			res.valid = 1'b1;
			res.ent   = held_entries.pop_front();
		end
		res.count = 5'(held_entries.size());
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		entry_t   req;
		if (!arst_n) begin
			held_entries.delete();
			awaited_results.delete();
		end else begin
			// The result of an earlier transaction is checked before a new one is taken.
			if (done) begin
				if (awaited_results.size() == 0) begin
					$display("%0t ns: result with no transaction outstanding", $time);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					compare_field("out_valid", 16'(out_valid), 16'(want.valid));
					compare_field("status", 16'(status), 16'(want.code));
					compare_field("entry_count", 16'(entry_count), 16'(want.count));
					compare_field("out_priority", 16'(out_priority), 16'(want.ent.prio));
					compare_field("out_year", 16'(out_year), 16'(want.ent.stamp.year));
					compare_field("out_month", 16'(out_month), 16'(want.ent.stamp.month));
					compare_field("out_day", 16'(out_day), 16'(want.ent.stamp.day));
					compare_field("out_hour", 16'(out_hour), 16'(want.ent.stamp.hour));
					compare_field("out_minute", 16'(out_minute), 16'(want.ent.stamp.minute));
					compare_field("out_tag", out_tag, want.ent.tag);
				end
			end
			if (start && !busy) begin
				req.prio         = req_priority;
				req.stamp.year   = req_year;
				req.stamp.month  = req_month;
				req.stamp.day    = req_day;
				req.stamp.hour   = req_hour;
				req.stamp.minute = req_minute;
				req.tag          = req_tag;
				awaited_results.push_back(apply_request(func, req));
			end
		end
		results_awaited = awaited_results.size();
	end

endmodule

// File: tb/sv/tb_priority_date_ordered_queue_top.sv
// Testbench top for the priority and date ordered queue: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_priority_date_ordered_queue_top;
	import pdoq_pkg::*;

	localparam int DEPTH = 16;

	// Clock and reset. Reset is held low at the start and never again.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Request channel. Every input has a known value from time zero.
	logic        start        = 1'b0;
	logic        func         = FUNC_PUSH;
	logic [7:0]  req_priority = '0;
	logic [11:0] req_year     = '0;
	logic [3:0]  req_month    = '0;
	logic [4:0]  req_day      = '0;
	logic [4:0]  req_hour     = '0;
	logic [5:0]  req_minute   = '0;
	logic [15:0] req_tag      = '0;

	// Result channel.
	logic        busy;
	logic        done;
	logic        out_valid;
	logic [1:0]  status;
	logic [4:0]  entry_count;
	logic [7:0]  out_priority;
	logic [11:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic [4:0]  out_hour;
	logic [5:0]  out_minute;
	logic [15:0] out_tag;

	int unsigned mismatch_count;
	int unsigned results_awaited;

	// When set, the sender issues transactions back to back with no idle cycles.
	bit no_idle = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	priority_date_ordered_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.req_priority(req_priority),
		.req_year(req_year),
		.req_month(req_month),
		.req_day(req_day),
		.req_hour(req_hour),
		.req_minute(req_minute),
		.req_tag(req_tag),
		.done(done),
		.out_valid(out_valid),
		.status(status),
		.entry_count(entry_count),
		.out_priority(out_priority),
		.out_year(out_year),
		.out_month(out_month),
		.out_day(out_day),
		.out_hour(out_hour),
		.out_minute(out_minute),
		.out_tag(out_tag)
	);

	// The checker sits beside the block, watches both channels and counts mismatches.
	pdoq_result_checker #(
		.QUEUE_DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.req_priority(req_priority),
		.req_year(req_year),
		.req_month(req_month),
		.req_day(req_day),
		.req_hour(req_hour),
		.req_minute(req_minute),
		.req_tag(req_tag),
		.done(done),
		.out_valid(out_valid),
		.status(status),
		.entry_count(entry_count),
		.out_priority(out_priority),
		.out_year(out_year),
		.out_month(out_month),
		.out_day(out_day),
		.out_hour(out_hour),
		.out_minute(out_minute),
		.out_tag(out_tag),
		.mismatch_count(mismatch_count),
		.results_awaited(results_awaited)
	);

	// Builds a request from its separate fields.
	function automatic entry_t make_entry(input logic [7:0] prio, input logic [11:0] year,
			input logic [3:0] month, input logic [4:0] day, input logic [4:0] hour,
			input logic [5:0] minute, input logic [15:0] tag);
		entry_t e;
		e.prio         = prio;
		e.stamp.year   = year;
		e.stamp.month  = month;
		e.stamp.day    = day;
		e.stamp.hour   = hour;
		e.stamp.minute = minute;
		e.tag          = tag;
		return e;
	endfunction

	// Random request. Half of the dates and most priorities come from small pools, so
	// that equal priorities and equal or near dates meet often and exercise the tie rules.
	function automatic entry_t random_entry();
		entry_t e;
		case ($urandom_range(0, 3))
			0: e.prio = 8'($urandom_range(0, 255));
			1: e.prio = 8'd0;
			2: e.prio = 8'd255;
			default: e.prio = 8'($urandom_range(1, 3));
		endcase
		if ($urandom_range(0, 1) == 0) begin
			e.stamp.year   = 12'($urandom_range(2000, 2001));
			e.stamp.month  = 4'($urandom_range(1, 2));
			e.stamp.day    = 5'($urandom_range(1, 2));
			e.stamp.hour   = 5'($urandom_range(0, 1));
			e.stamp.minute = 6'($urandom_range(0, 1));
		end else begin
			e.stamp.year   = 12'($urandom_range(0, 4095));
			e.stamp.month  = 4'($urandom_range(1, 12));
			e.stamp.day    = 5'($urandom_range(1, 31));
			e.stamp.hour   = 5'($urandom_range(0, 23));
			e.stamp.minute = 6'($urandom_range(0, 59));
		end
		e.tag = 16'($urandom_range(0, 65535));
		return e;
	endfunction

	// Idle cycles before a transaction: mostly none, often a few, now and then a long pause.
	function automatic int unsigned random_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Drives one transaction and returns at the edge that accepts it. Start stays high
	// after acceptance; the next call either keeps it high for a back-to-back transaction
	// or lowers it for the gap, so start never gets two assignments at one edge.
	task automatic submit_request(input logic op, input entry_t e, input int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		func         <= op;
		req_priority <= e.prio;
		req_year     <= e.stamp.year;
		req_month    <= e.stamp.month;
		req_day      <= e.stamp.day;
		req_hour     <= e.stamp.hour;
		req_minute   <= e.stamp.minute;
		req_tag      <= e.tag;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic push_request(input entry_t e);
		submit_request(FUNC_PUSH, e, random_gap());
	endtask

	// A pop carries random content in its unused request fields, which the block must ignore.
	task automatic pop_request();
		submit_request(FUNC_POP, random_entry(), random_gap());
	endtask

	// Directed part: the empty and full cases, field extremes and the ordering rules.
	task automatic run_directed();
		// Pop on an empty queue right after reset.
		pop_request();
		// Equal priorities: an earlier date goes in front, an equal date goes in front of
		// the older entry, and a later date goes behind the whole group.
		push_request(make_entry(8'h80, 12'd2020, 4'd6, 5'd15, 5'd12, 6'd30, 16'h0001));
		push_request(make_entry(8'h80, 12'd2020, 4'd6, 5'd15, 5'd12, 6'd29, 16'h0002));
		push_request(make_entry(8'h80, 12'd2020, 4'd6, 5'd15, 5'd12, 6'd30, 16'h0003));
		// Highest priority with every date field at its maximum goes to the head.
		push_request(make_entry(8'hFF, 12'd4095, 4'd12, 5'd31, 5'd23, 6'd59, 16'hFFFF));
		// Lowest priority with every date field at its minimum goes to the tail.
		push_request(make_entry(8'h00, 12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 16'h0000));
		push_request(make_entry(8'h80, 12'd2021, 4'd1, 5'd1, 5'd0, 6'd0, 16'h0004));
		// Fill the rest of the queue, then push once more onto the full queue.
		for (int i = 0; i < DEPTH - 6; i++)
			push_request(random_entry());
		push_request(random_entry());
		repeat (5) pop_request();
	endtask

	// Random part in blocks of fifty transactions. Each block draws its own mix of pushes
	// and pops, so the queue swings between empty and full, and some blocks run with no idle cycles.
	task automatic run_random();
		int unsigned push_pct;
		for (int blk = 0; blk < 22; blk++) begin
			case ($urandom_range(0, 3))
				0: push_pct = 20;
				1: push_pct = 50;
				2: push_pct = 75;
				default: push_pct = 95;
			endcase
			no_idle = ($urandom_range(0, 4) == 0);
			for (int n = 0; n < 50; n++) begin
				if ($urandom_range(0, 99) < push_pct)
					push_request(random_entry());
				else
					pop_request();
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random();

		// All stimulus is accepted; drop start and wait for the outstanding results.
		start <= 1'b0;
		@(posedge clk);
		while (results_awaited != 0)
			@(negedge clk);
		// Let a few more cycles pass so that any stray result would still be caught.
		repeat (40) @(posedge clk);

		if (mismatch_count == 0 && results_awaited == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: a hang in any handshake ends the run as a failure.
	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/pdoq_pkg.sv
hw/rtl/pdoq_ring_mem.sv
hw/rtl/priority_date_ordered_queue_top.sv
tb/sv/pdoq_result_checker.sv
tb/sv/tb_priority_date_ordered_queue_top.sv
